>>> design/ccrd_pkg.sv
// Shared types, register map and helpers for the coprocessor control register block.
`default_nettype none
package ccrd_pkg;

  localparam int LocalAddrBits = 12;

  typedef enum logic [1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpTick  = 2'd2
  } op_e;

  localparam logic [4:0] RegLocalAddr = 5'd0;
  localparam logic [4:0] RegDramAddr  = 5'd1;
  localparam logic [4:0] RegReadLen   = 5'd2;
  localparam logic [4:0] RegWriteLen  = 5'd3;
  localparam logic [4:0] RegStatus    = 5'd4;
  localparam logic [4:0] RegDmaFull   = 5'd5;
  localparam logic [4:0] RegDmaBusy   = 5'd6;
  localparam logic [4:0] RegSemaphore = 5'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] read_data;
    logic [23:0] dram_address;
    logic [11:0] local_address;
    logic        local_select;
    logic        toward_dram;
    logic        last_transfer;
    logic        irq_level;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic dir;
    logic tick;
  } dma_ctrl_t;

  typedef struct packed {
    logic        active;
    logic        dir;
    logic [23:0] dram_addr;
    logic [11:0] local_addr;
    logic        last;
  } dma_stat_t;

  // Align the 12-bit base to a doubleword and fit it to the cursor width.
  function automatic logic [LocalAddrBits-1:0] base_to_cursor(input logic [11:0] base);
    logic [31:0] w;
    w = 32'(base & 12'hFF8);
    return w[LocalAddrBits-1:0];
  endfunction

  function automatic logic [11:0] cursor_to_addr(input logic [LocalAddrBits-1:0] cur);
    logic [31:0] w;
    w = 32'(cur);
    return w[11:0];
  endfunction

endpackage
`default_nettype wire

>>> design/coprocessor_control_regs_dma.sv
// Top level: control registers, status bits, semaphore and DMA tick handling.
// A read, or a tick during a DMA, gives its result via the input then the result register.
// Throughput: one item per cycle unless stalled; each item is one register or counter update.
// The input register takes a new item whenever the result register is empty or being taken.
// Reset: asynchronous, active low; state zero except halted bit (set); payload regs not reset.
`default_nettype none
module coprocessor_control_regs_dma import ccrd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  // input register
  logic     in_vq;
  in_item_t in_q;

  // result register
  logic      out_vq, out_vd;
  out_item_t out_q, out_d;

  // architectural state
  logic [11:0] local_base_q, local_base_d;
  logic        local_src_q, local_src_d;
  logic [23:0] dram_base_q, dram_base_d;
  logic [31:0] rd_len_q, rd_len_d;
  logic [31:0] wr_len_q, wr_len_d;
  logic        halted_q, halted_d;
  logic        sstep_q, sstep_d;
  logic        intbrk_q, intbrk_d;
  logic [7:0]  signals_q, signals_d;
  logic        sem_q, sem_d;
  logic        irq_q, irq_d;

  logic        fire;
  logic        is_read, is_write, is_tick;
  logic [31:0] rdata;
  dma_ctrl_t   dma_ctrl;
  dma_stat_t   dma_stat;

  assign fire       = in_vq && (!out_vq || !out_stall_i);
  assign in_stall_o = in_vq && !fire;
  assign is_read    = fire && (in_q.operation == OpRead);
  assign is_write   = fire && (in_q.operation == OpWrite);
  assign is_tick    = fire && (in_q.operation == OpTick);

  always_comb begin
    case (in_q.reg_index)
      RegLocalAddr: rdata = {19'd0, local_src_q, local_base_q};
      RegDramAddr:  rdata = {8'd0, dram_base_q};
      RegReadLen:   rdata = rd_len_q;
      RegWriteLen:  rdata = wr_len_q;
      RegStatus:    rdata = {17'd0, signals_q, intbrk_q, sstep_q, 2'b00,
                             dma_stat.active, 1'b0, halted_q};
      RegDmaFull:   rdata = '0;
      RegDmaBusy:   rdata = {31'd0, dma_stat.active};
      RegSemaphore: rdata = {31'd0, sem_q};
      default:      rdata = '0;
    endcase
  end

  assign dma_ctrl.start = is_write && ((in_q.reg_index == RegReadLen) ||
                                       (in_q.reg_index == RegWriteLen));
  assign dma_ctrl.dir   = (in_q.reg_index == RegWriteLen);
  assign dma_ctrl.tick  = is_tick;

  ccrd_dma u_dma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (dma_ctrl),
    .read_len_i   (rd_len_q),
    .write_len_i  (wr_len_q),
    .dram_base_i  (dram_base_q),
    .local_base_i (local_base_q),
    .stat_o       (dma_stat)
  );

  always_comb begin
    logic [31:0] d;
    d            = in_q.write_data;
    local_base_d = local_base_q;
    local_src_d  = local_src_q;
    dram_base_d  = dram_base_q;
    rd_len_d     = rd_len_q;
    wr_len_d     = wr_len_q;
    halted_d     = halted_q;
    sstep_d      = sstep_q;
    intbrk_d     = intbrk_q;
    signals_d    = signals_q;
    sem_d        = sem_q;
    irq_d        = irq_q;
    if (is_read && (in_q.reg_index == RegSemaphore)) begin
      sem_d = 1'b1;
    end
    if (is_write) begin
      case (in_q.reg_index)
        RegLocalAddr: begin
          local_base_d = d[11:0];
          local_src_d  = d[12];
        end
        RegDramAddr:  dram_base_d = d[23:0];
        RegReadLen:   rd_len_d = d;
        RegWriteLen:  wr_len_d = d;
        RegStatus: begin
          // clear first, then set: set wins
          if (d[0]) halted_d = 1'b0;
          if (d[1]) halted_d = 1'b1;
          if (d[3]) irq_d = 1'b0;
          if (d[4]) irq_d = 1'b1;
          if (d[5]) sstep_d = 1'b0;
          if (d[6]) sstep_d = 1'b1;
          if (d[7]) intbrk_d = 1'b0;
          if (d[8]) intbrk_d = 1'b1;
          for (int k = 0; k < 8; k++) begin
            if (d[9 + 2*k])  signals_d[k] = 1'b0;
            if (d[10 + 2*k]) signals_d[k] = 1'b1;
          end
        end
        RegSemaphore: if (!d[0]) sem_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_vd = out_vq;
    out_d  = out_q;
    if (out_vq && !out_stall_i) out_vd = 1'b0;
    if (is_read) begin
      out_vd = 1'b1;
      out_d  = '0;
      out_d.read_data = rdata;
      out_d.irq_level = irq_q;
    end else if (is_tick && dma_stat.active) begin
      out_vd = 1'b1;
      out_d  = '0;
      out_d.result_kind   = 1'b1;
      out_d.dram_address  = dma_stat.dram_addr;
      out_d.local_address = dma_stat.local_addr;
      out_d.local_select  = local_src_q;
      out_d.toward_dram   = dma_stat.dir;
      out_d.last_transfer = dma_stat.last;
      out_d.irq_level     = irq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq        <= 1'b0;
      out_vq       <= 1'b0;
      local_base_q <= '0;
      local_src_q  <= 1'b0;
      dram_base_q  <= '0;
      rd_len_q     <= '0;
      wr_len_q     <= '0;
      halted_q     <= 1'b1;
      sstep_q      <= 1'b0;
      intbrk_q     <= 1'b0;
      signals_q    <= '0;
      sem_q        <= 1'b0;
      irq_q        <= 1'b0;
    end else begin
      if (!in_stall_o) in_vq <= in_valid_i;
      out_vq       <= out_vd;
      local_base_q <= local_base_d;
      local_src_q  <= local_src_d;
      dram_base_q  <= dram_base_d;
      rd_len_q     <= rd_len_d;
      wr_len_q     <= wr_len_d;
      halted_q     <= halted_d;
      sstep_q      <= sstep_d;
      intbrk_q     <= intbrk_d;
      signals_q    <= signals_d;
      sem_q        <= sem_d;
      irq_q        <= irq_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) in_q <= in_item_i;
    out_q <= out_d;
  end

  assign out_valid_o = out_vq;
  assign out_item_o  = out_q;

  a_last_ends_dma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tick && dma_stat.active && dma_stat.last |=> !dma_stat.active)
    else $error("DMA still active after its last doubleword");

  a_sem_set_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read && (in_q.reg_index == RegSemaphore) |=> sem_q)
    else $error("semaphore not set after read");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vq && out_vq && out_stall_i |=> in_vq && $stable(in_q))
    else $error("pending item lost while result register stalled");

  a_start_activates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dma_ctrl.start |=> dma_stat.active)
    else $error("length write did not start a transfer");

endmodule
`default_nettype wire

>>> design/ccrd_dma.sv
// Strided DMA address generator: line and word counters with DRAM and local cursors.
`default_nettype none
module ccrd_dma import ccrd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dma_ctrl_t   ctrl_i,
  input  wire logic [31:0] read_len_i,
  input  wire logic [31:0] write_len_i,
  input  wire logic [23:0] dram_base_i,
  input  wire logic [11:0] local_base_i,
  output dma_stat_t        stat_o
);

  logic                     active_q, active_d;
  logic                     dir_q, dir_d;
  logic [7:0]               line_q, line_d;
  logic [8:0]               word_q, word_d;
  logic [23:0]              dram_q, dram_d;
  logic [LocalAddrBits-1:0] local_q, local_d;

  logic [31:0] len;
  logic        last_word;
  logic        last;

  assign len       = dir_q ? write_len_i : read_len_i;
  assign last_word = word_q >= len[11:3];
  assign last      = last_word && (line_q >= len[19:12]);

  always_comb begin
    active_d = active_q;
    dir_d    = dir_q;
    line_d   = line_q;
    word_d   = word_q;
    dram_d   = dram_q;
    local_d  = local_q;
    if (ctrl_i.start) begin
      active_d = 1'b1;
      dir_d    = ctrl_i.dir;
      line_d   = '0;
      word_d   = '0;
      dram_d   = dram_base_i & 24'hFFFFF8;
      local_d  = base_to_cursor(local_base_i);
    end else if (ctrl_i.tick && active_q) begin
      local_d = local_q + LocalAddrBits'(8);
      if (last) begin
        active_d = 1'b0;
        word_d   = '0;
        line_d   = '0;
      end else if (last_word) begin
        word_d = '0;
        line_d = line_q + 8'd1;
        dram_d = dram_q + 24'd8 + 24'(len[31:20]);
      end else begin
        word_d = word_q + 9'd1;
        dram_d = dram_q + 24'd8;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      dir_q    <= 1'b0;
      line_q   <= '0;
      word_q   <= '0;
      dram_q   <= '0;
      local_q  <= '0;
    end else begin
      active_q <= active_d;
      dir_q    <= dir_d;
      line_q   <= line_d;
      word_q   <= word_d;
      dram_q   <= dram_d;
      local_q  <= local_d;
    end
  end

  assign stat_o.active     = active_q;
  assign stat_o.dir        = dir_q;
  assign stat_o.dram_addr  = dram_q;
  assign stat_o.local_addr = cursor_to_addr(local_q);
  assign stat_o.last       = last;

endmodule
`default_nettype wire
